[sv/sha_pkg.sv]
// shared types, constants and round functions for the sha-256 stream hasher
`timescale 1ns / 1ps

package sha_pkg;

  // control into the compression engine
  typedef struct packed {
    logic        start;
    logic        init_chain;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
  } eng_ctrl_t;

  // status back from the compression engine
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRnd = 6'd63;

  // initial chaining values
  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    logic [31:0] v;
    unique case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  // round constants
  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] v;
    unique case (t)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491; 6'd2:  v = 32'hb5c0fbcf;
      6'd3:  v = 32'he9b5dba5; 6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5; 6'd8:  v = 32'hd807aa98;
      6'd9:  v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

[sv/sha_ifs.sv]
// stream channel interfaces for message bytes and digest words
`timescale 1ns / 1ps

interface sha_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

[sv/sha_engine.sv]
// sha-256 compression engine around a 16-word schedule memory
`timescale 1ns / 1ps

module sha_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  eng_ctrl_t   ctrl_i,
  output eng_stat_t   stat_o,
  output logic [31:0] chain_o [8]
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_RDA  = 2'd1;
  localparam logic [1:0] E_RDB  = 2'd2;
  localparam logic [1:0] E_FIN  = 2'd3;

  logic [1:0]  est_q, est_d;
  logic [5:0]  t_q;
  logic [31:0] chain_q [8];
  logic [31:0] v_q [8];
  logic [31:0] a15_q, b16_q, w1_q, w2_q;

  // schedule memory, two read ports, one write port
  logic [31:0] sched_mem [16];
  logic [3:0]  raddr0, raddr1, waddr;
  logic [31:0] rd0_q, rd1_q, wdata;
  logic        we;

  logic [31:0] w_cur, t1, t2;
  logic [3:0]  tl;

  assign tl = t_q[3:0];

  // schedule word for the current round
  always_comb begin
    if (t_q[5:4] == 2'b00) begin
      w_cur = b16_q;
    end else begin
      w_cur = small_sig1(w2_q) + rd0_q + small_sig0(a15_q) + b16_q;
    end
    t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha_k(t_q) + w_cur;
    t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // read addresses and write port
  always_comb begin
    raddr0 = tl + 4'd2;
    raddr1 = tl + 4'd1;
    we     = 1'b0;
    waddr  = ctrl_i.wr_addr;
    wdata  = ctrl_i.wr_data;
    unique case (est_q)
      E_IDLE: begin
        raddr0 = 4'd1;
        raddr1 = 4'd0;
        we     = ctrl_i.wr_en;
      end
      E_RDA: begin
        raddr0 = tl + 4'd9;
      end
      E_RDB: begin
        we    = (t_q[5:4] != 2'b00);
        waddr = tl;
        wdata = w_cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      sched_mem[waddr] <= wdata;
    end
    rd0_q <= sched_mem[raddr0];
    rd1_q <= sched_mem[raddr1];
  end

  // sequencer
  always_comb begin
    est_d = est_q;
    unique case (est_q)
      E_IDLE: if (ctrl_i.start) est_d = E_RDA;
      E_RDA:  est_d = E_RDB;
      E_RDB:  if (t_q == LastRnd) est_d = E_FIN; else est_d = E_RDA;
      default: est_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= E_IDLE;
      t_q   <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
    end else begin
      est_q <= est_d;
      if (est_q == E_IDLE && ctrl_i.start) t_q <= '0;
      else if (est_q == E_RDB) t_q <= t_q + 6'd1;
      if (est_q == E_FIN) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
      end else if (ctrl_i.init_chain) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
      end
    end
  end

  // round datapath
  always_ff @(posedge clk_i) begin
    if (est_q == E_IDLE && ctrl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
    end
    if (est_q == E_RDA) begin
      a15_q <= rd0_q;
      b16_q <= rd1_q;
    end
    if (est_q == E_RDB) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      w1_q   <= w_cur;
      w2_q   <= w1_q;
    end
  end

  assign stat_o.busy = (est_q != E_IDLE);
  assign stat_o.done = (est_q == E_FIN);
  assign chain_o     = chain_q;

endmodule

[sv/sha256_stream_hasher.sv]
// sha-256 stream hasher top level: byte packing, padding and digest output
//
//  channel | dir | payload                                 | handshake
//  in_i    | in  | data_byte[7:0], last_byte               | valid/ready
//  out_o   | out | digest_word[63:0], word_index, last_word | valid/ready
//
// one byte per cycle is taken while the block buffer fills; a full block
// then runs 64 rounds, each a schedule memory read state and a round state,
// and then a finish state. padding adds the pad bytes, and a second block
// when the length does not fit. reset returns the chaining values to their
// initial values. no byte is taken while the engine runs or the digest
// waits; a stalled output holds its word.
`timescale 1ns / 1ps

module sha256_stream_hasher import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha_byte_if.sink     in_i,
  sha_digest_if.source out_o
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_P80  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  st_q, ret_q, ns;
  logic [5:0]  pos_q;
  logic [60:0] cnt_q;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  idx_q;
  logic        in_acc, put, out_acc;
  logic [7:0]  byte_v;
  logic [63:0] len_sh;
  eng_ctrl_t   ctrl;
  eng_stat_t   stat;
  logic [31:0] chain [8];

  sha_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .chain_o (chain)
  );

  assign in_i.ready = (st_q == S_IN);
  assign in_acc     = in_i.valid && (st_q == S_IN);
  assign put        = in_acc || st_q == S_P80 || st_q == S_ZERO || st_q == S_LEN;
  assign out_acc    = out_o.valid && out_o.ready;
  assign len_sh     = {cnt_q, 3'b000} << {pos_q[2:0], 3'b000};

  // byte source
  always_comb begin
    unique case (st_q)
      S_IN:    byte_v = in_i.data_byte;
      S_P80:   byte_v = PadByte;
      S_LEN:   byte_v = len_sh[63:56];
      default: byte_v = 8'h00;
    endcase
  end

  // word packing, big-endian
  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    acc_d = {byte_v, 24'h0};
      2'd1:    acc_d = {acc_q[31:24], byte_v, 16'h0};
      2'd2:    acc_d = {acc_q[31:16], byte_v, 8'h0};
      default: acc_d = {acc_q[31:8], byte_v};
    endcase
  end

  // state after the current byte
  always_comb begin
    unique case (st_q)
      S_IN:          ns = in_i.last_byte ? S_P80 : S_IN;
      S_P80, S_ZERO: ns = (pos_q == LenPos - 6'd1) ? S_LEN : S_ZERO;
      S_LEN:         ns = S_OUT;
      default:       ns = st_q;
    endcase
  end

  assign ctrl.start      = put && (pos_q == LastPos);
  assign ctrl.init_chain = out_acc && out_o.last_word;
  assign ctrl.wr_en      = put && (pos_q[1:0] == 2'd3);
  assign ctrl.wr_addr    = pos_q[5:2];
  assign ctrl.wr_data    = acc_d;

  always_ff @(posedge clk_i) begin
    if (put) acc_q <= acc_d;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IN;
      ret_q <= S_IN;
      pos_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (in_acc) cnt_q <= cnt_q + 61'd1;
      if (put) begin
        pos_q <= pos_q + 6'd1;
        if (pos_q == LastPos) begin
          st_q  <= S_COMP;
          ret_q <= ns;
        end else if (st_q != S_LEN) begin
          st_q <= ns;
        end
      end else if (st_q == S_COMP) begin
        if (stat.done) st_q <= ret_q;
      end else if (out_acc) begin
        idx_q <= idx_q + 2'd1;
        if (out_o.last_word) begin
          st_q  <= S_IN;
          cnt_q <= '0;
        end
      end
    end
  end

  // digest words
  assign out_o.valid       = (st_q == S_OUT);
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 2'd3);
  assign out_o.digest_word = {chain[{idx_q, 1'b0}], chain[{idx_q, 1'b1}]};

endmodule

[sv/sha_checker.sv]
// port-level assertions for the sha-256 stream hasher
`timescale 1ns / 1ps

module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_word,
  input logic [1:0]  out_index,
  input logic        out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index))
    else $error("digest word changed while stalled");

  // last flag only on the final slice
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_index == 2'd3)))
    else $error("last flag and slice index disagree");

  // slices follow each other without a gap
  a_next_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid && out_index == $past(out_index) + 2'd1)
    else $error("digest slice missing or out of order");

  // no byte taken while the digest is shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("byte accepted during digest output");

  // digest ends after the final slice
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("output did not end after final slice");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_word  (out_o.digest_word),
  .out_index (out_o.word_index),
  .out_last  (out_o.last_word)
);
